// ----- rtl/mie_pkg.sv -----
// shared types and constants of the modular inverse block
// datapath width, controller states, command and status bundles
// no dependencies
`default_nettype none

package mie_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int MOD_WIDTH  = WORD_WIDTH - 1;
  localparam int COEF_WIDTH = WORD_WIDTH + 1;
  localparam int CNT_WIDTH  = $clog2(WORD_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_FIXUP,
    S_TEST,
    S_STEP,
    S_SWAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_iter;
    logic red_done;
    logic step_init;
    logic step_commit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic div_last;
    logic rem_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/modular_inverse_extended_euclid.sv -----
// top level of the modular inverse block (extended euclid, floor division)
// instantiates mie_ctrl and mie_datapath; uses mie_pkg
//
//  channel | ports                                          | transfer
//  --------+------------------------------------------------+--------------------------
//  input   | start, busy, in_value, in_modulus              | start high, busy low
//  result  | out_valid, out_inverse, out_common_divisor,    | out_valid high for one
//          | out_invertible                                 | cycle, cannot be stalled
//
// one item at a time: a load, value reduction through the restoring divider, a
//   fix-up state, then euclid steps (test, divider iterations with the
//   multiply-subtract folded in, swap) until the new remainder is zero
// about 46 steps worst case for 31-bit moduli; a zero modulus goes from the
//   reduction state straight to the done state
// the result strobe is registered from the done state and comes in the cycle after it, with busy already low
// synchronous active-low reset returns the controller to idle; no clearing pass
// results are never held off, so nothing inside ever waits on the receiver
`default_nettype none

module modular_inverse_extended_euclid (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [mie_pkg::WORD_WIDTH-1:0] in_value,
  input  wire logic [mie_pkg::MOD_WIDTH-1:0]  in_modulus,
  output logic                                out_valid,
  output logic [mie_pkg::MOD_WIDTH-1:0]       out_inverse,
  output logic [mie_pkg::MOD_WIDTH-1:0]       out_common_divisor,
  output logic                                out_invertible
);

  // command and status bundles between controller and datapath
  mie_pkg::dp_cmd_t    cmd;
  mie_pkg::dp_status_t status;

  // state machine: sequences reduction, steps and the result strobe
  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // shared divider, coefficient accumulator and result registers
  mie_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_value           (in_value),
    .in_modulus         (in_modulus),
    .out_inverse        (out_inverse),
    .out_common_divisor (out_common_divisor),
    .out_invertible     (out_invertible)
  );

endmodule

`default_nettype wire

// ----- rtl/mie_datapath.sv -----
// datapath of the modular inverse block: restoring divider, coefficient
// accumulator and euclid registers; uses mie_pkg
`default_nettype none

module mie_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mie_pkg::dp_cmd_t            cmd,
  output mie_pkg::dp_status_t              status,
  input  wire logic [mie_pkg::WORD_WIDTH-1:0] in_value,
  input  wire logic [mie_pkg::MOD_WIDTH-1:0]  in_modulus,
  output logic [mie_pkg::MOD_WIDTH-1:0]    out_inverse,
  output logic [mie_pkg::MOD_WIDTH-1:0]    out_common_divisor,
  output logic                             out_invertible
);

  localparam int W  = mie_pkg::WORD_WIDTH;
  localparam int MW = mie_pkg::MOD_WIDTH;
  localparam int CW = mie_pkg::COEF_WIDTH;
  localparam int NW = mie_pkg::CNT_WIDTH;

  logic [MW-1:0] mod_r;
  logic          neg_r;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  old_rem_r, old_rem_nxt;
  logic [W-1:0]  new_rem_r, new_rem_nxt;
  logic [CW-1:0] old_coef_r, old_coef_nxt;
  logic [CW-1:0] new_coef_r, new_coef_nxt;

  logic [W:0]    trial;
  logic          ge;
  logic [W-1:0]  red_val;
  logic [CW-1:0] inv_sum;

  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  // floor reduction fix-up for negative values
  assign red_val = (neg_r && (rem_r != '0)) ? ({1'b0, mod_r} - rem_r) : rem_r;

  assign inv_sum = old_coef_r[CW-1] ? (old_coef_r + CW'(mod_r)) : old_coef_r;

  assign status.mod_zero = (mod_r == '0);
  assign status.div_last = (cnt_r == NW'(W - 1));
  assign status.rem_zero = (new_rem_r == '0);

  always_comb begin
    quo_nxt      = quo_r;
    dvs_nxt      = dvs_r;
    rem_nxt      = rem_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    old_rem_nxt  = old_rem_r;
    new_rem_nxt  = new_rem_r;
    old_coef_nxt = old_coef_r;
    new_coef_nxt = new_coef_r;
    if (cmd.load) begin
      quo_nxt      = in_value[W-1] ? (~in_value + W'(1)) : in_value;
      dvs_nxt      = {1'b0, in_modulus};
      rem_nxt      = '0;
      acc_nxt      = '0;
      cnt_nxt      = '0;
      old_rem_nxt  = '0;
      new_rem_nxt  = '0;
      old_coef_nxt = '0;
      new_coef_nxt = '0;
    end
    if (cmd.div_iter) begin
      quo_nxt = {quo_r[W-2:0], ge};
      rem_nxt = ge ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
      // horner form of quotient times new coefficient
      acc_nxt = {acc_r[CW-2:0], 1'b0} + (ge ? new_coef_r : '0);
      cnt_nxt = cnt_r + NW'(1);
    end
    if (cmd.red_done) begin
      old_rem_nxt  = red_val;
      new_rem_nxt  = {1'b0, mod_r};
      old_coef_nxt = CW'(1);
      new_coef_nxt = '0;
    end
    if (cmd.step_init) begin
      quo_nxt = old_rem_r;
      dvs_nxt = new_rem_r;
      rem_nxt = '0;
      acc_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.step_commit) begin
      old_coef_nxt = new_coef_r;
      new_coef_nxt = old_coef_r - acc_r;
      old_rem_nxt  = new_rem_r;
      new_rem_nxt  = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      old_rem_r  <= '0;
      new_rem_r  <= '0;
      old_coef_r <= '0;
      new_coef_r <= '0;
      mod_r      <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      old_rem_r  <= old_rem_nxt;
      new_rem_r  <= new_rem_nxt;
      old_coef_r <= old_coef_nxt;
      new_coef_r <= new_coef_nxt;
      if (cmd.load) begin
        mod_r <= in_modulus;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    if (cmd.load) begin
      neg_r <= in_value[W-1];
    end
    if (cmd.finish) begin
      out_inverse        <= inv_sum[MW-1:0];
      out_common_divisor <= old_rem_r[MW-1:0];
      out_invertible     <= (old_rem_r == W'(1));
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mie_ctrl.sv -----
// controller state machine of the modular inverse block
// sequences reduction, euclid steps and result strobe; uses mie_pkg
`default_nettype none

module mie_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  output logic                     out_valid,
  input  wire mie_pkg::dp_status_t status,
  output mie_pkg::dp_cmd_t         cmd
);

  mie_pkg::state_t state_r, state_nxt;
  logic            valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mie_pkg::S_IDLE:   if (start) state_nxt = mie_pkg::S_REDUCE;
      mie_pkg::S_REDUCE: begin
        if (status.mod_zero)      state_nxt = mie_pkg::S_DONE;
        else if (status.div_last) state_nxt = mie_pkg::S_FIXUP;
      end
      mie_pkg::S_FIXUP:  state_nxt = mie_pkg::S_TEST;
      mie_pkg::S_TEST:   state_nxt = status.rem_zero ? mie_pkg::S_DONE : mie_pkg::S_STEP;
      mie_pkg::S_STEP:   if (status.div_last) state_nxt = mie_pkg::S_SWAP;
      mie_pkg::S_SWAP:   state_nxt = mie_pkg::S_TEST;
      mie_pkg::S_DONE:   state_nxt = mie_pkg::S_IDLE;
      default:           state_nxt = mie_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      mie_pkg::S_IDLE:   cmd.load        = start;
      mie_pkg::S_REDUCE: cmd.div_iter    = !status.mod_zero;
      mie_pkg::S_FIXUP:  cmd.red_done    = 1'b1;
      mie_pkg::S_TEST:   cmd.step_init   = !status.rem_zero;
      mie_pkg::S_STEP:   cmd.div_iter    = 1'b1;
      mie_pkg::S_SWAP:   cmd.step_commit = 1'b1;
      mie_pkg::S_DONE:   cmd.finish      = 1'b1;
      default:           cmd = '0;
    endcase
  end

  assign busy      = (state_r != mie_pkg::S_IDLE);
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mie_pkg::S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == mie_pkg::S_DONE);
    end
  end

endmodule

`default_nettype wire
